// ===== rtl/tll_pkg.sv =====
// Shared types, constants and table lookups for the thermistor table linearizer.
// No dependencies; every other file in the block imports this package.
package tll_pkg;

  localparam int KIND_W       = 4;
  localparam int CNT_W        = 10;
  localparam int TEMP_W       = 20;
  localparam int IDX_W        = 5;
  localparam int ROW_W        = 3;
  localparam int SPAN_W       = 15;
  localparam int QUO_W        = 7;
  localparam int QUO_TOP      = QUO_W - 1;
  localparam int BIT_W        = 3;
  localparam int REM_W        = 17;
  localparam int SEGSUM_W     = 19;
  localparam int PROD_W       = SPAN_W + QUO_W;
  localparam int RECIP_SH     = 29;
  localparam int RECIP_W      = 23;
  localparam int RECIP_M      = 5368710;
  localparam int SCALE        = 100;
  localparam int KINDS        = 10;
  localparam int ROWS         = 5;
  localparam int TABLE_POINTS = 17;
  localparam int SEGMENTS_DEF = 16;
  localparam int QUEUE_DEPTH  = 2;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_HIGH,
    CLS_LOW,
    CLS_INTERP
  } tll_cls_t;

  typedef struct packed {
    tll_cls_t           cls;
    logic [KIND_W-1:0]  sel;
    logic [CNT_W-1:0]   count;
  } tll_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_SETUP,
    BK_DIV,
    BK_MUL,
    BK_RECIP,
    BK_SUM
  } tll_bk_state_t;

  localparam logic [CNT_W-1:0] COUNT_TABLE [ROWS][TABLE_POINTS] = '{
    '{10'd932, 10'd844, 10'd716, 10'd564, 10'd412, 10'd284, 10'd192, 10'd128,
      10'd84,  10'd56,  10'd40,  10'd28,  10'd20,  10'd16,  10'd12,  10'd8,  10'd4},
    '{10'd988, 10'd964, 10'd924, 10'd862, 10'd778, 10'd682, 10'd572, 10'd462,
      10'd364, 10'd282, 10'd214, 10'd164, 10'd128, 10'd100, 10'd76,  10'd62, 10'd48},
    '{10'd932, 10'd860, 10'd760, 10'd640, 10'd508, 10'd384, 10'd280, 10'd200,
      10'd140, 10'd100, 10'd72,  10'd52,  10'd36,  10'd28,  10'd20,  10'd16, 10'd12},
    '{10'd976, 10'd948, 10'd906, 10'd842, 10'd764, 10'd670, 10'd566, 10'd466,
      10'd376, 10'd296, 10'd234, 10'd180, 10'd144, 10'd114, 10'd90,  10'd76, 10'd60},
    '{10'd984, 10'd952, 10'd908, 10'd844, 10'd764, 10'd668, 10'd564, 10'd460,
      10'd368, 10'd288, 10'd220, 10'd168, 10'd132, 10'd100, 10'd76,  10'd60, 10'd48}
  };

  function automatic logic [CNT_W-1:0] table_count(input logic [ROW_W-1:0] row,
                                                   input logic [IDX_W-1:0] idx);
    logic [CNT_W-1:0] val;
    val = '0;
    if ((int'(row) < ROWS) && (int'(idx) < TABLE_POINTS)) begin
      val = COUNT_TABLE[row][idx];
    end
    return val;
  endfunction

  function automatic logic [SPAN_W-1:0] span_of(input logic [KIND_W-1:0] sel);
    logic [SPAN_W-1:0] val;
    unique case (sel)
      4'd0:                       val = 15'd11875;
      4'd1:                       val = 15'd21375;
      4'd2, 4'd4, 4'd6, 4'd8:     val = 15'd10000;
      4'd3, 4'd5, 4'd7, 4'd9:     val = 15'd18000;
      default:                    val = '0;
    endcase
    return val;
  endfunction

  function automatic logic signed [TEMP_W-1:0] limit_low(input logic [KIND_W-1:0] sel);
    logic signed [TEMP_W-1:0] val;
    unique case (sel)
      4'd8:    val = -20'sd50000;
      4'd9:    val = -20'sd58000;
      default: val = -20'sd40000;
    endcase
    return val;
  endfunction

  function automatic logic signed [TEMP_W-1:0] limit_high(input logic [KIND_W-1:0] sel);
    logic signed [TEMP_W-1:0] val;
    unique case (sel)
      4'd0:                  val = 20'sd150000;
      4'd1:                  val = 20'sd302000;
      4'd2, 4'd4, 4'd6:      val = 20'sd120000;
      4'd3, 4'd5, 4'd7:      val = 20'sd248000;
      4'd8:                  val = 20'sd110000;
      4'd9:                  val = 20'sd230000;
      default:               val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/thermistor_table_linearizer.sv =====
// Top level of the thermistor table linearizer: front, request queue and back.
// Depends on tll_pkg, tll_front, tll_fifo and tll_back.
//
// A request (start high while busy is low) carries a sensor kind and a ten-bit
// count and yields exactly one temperature in thousandths of a degree, shown
// for one cycle with out_valid; the receiver cannot stall, so it must take
// every strobe. A request passes through the front register and the queue
// before the back part takes it. For a clamped count or an unknown kind the
// back part registers the result as it takes the request and stays idle. An
// interpolated count holds the back part while it takes the request, runs the
// halving search over the sixteen segments (four steps and a final check),
// the setup step, the bit-serial division of seven quotient bits, and the
// multiply, reciprocal and sum steps of scaling; equal counts at both ends of
// the segment end it at setup with the low limit. The back part takes no new
// request until an interpolated reading is finished; the front register and
// the two-entry queue hold up to three requests, and busy rises only when the
// queue and the front register are both full.
module thermistor_table_linearizer
  import tll_pkg::*;
#(
  parameter int SEGMENTS = SEGMENTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [KIND_W-1:0]        in_sensor_kind,
  input  logic [CNT_W-1:0]         in_raw_count,
  output logic                     out_valid,
  output logic signed [TEMP_W-1:0] out_temperature
);

  logic       push, pop, q_full, q_empty;
  tll_entry_t push_data, pop_data;

  tll_front #(
    .SEGMENTS(SEGMENTS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_sensor_kind(in_sensor_kind),
    .in_raw_count  (in_raw_count),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full)
  );

  tll_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .full     (q_full),
    .empty    (q_empty)
  );

  tll_back #(
    .SEGMENTS(SEGMENTS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_temperature(out_temperature)
  );

endmodule

// ===== rtl/tll_fifo.sv =====
// Short request queue between the front and back parts of the linearizer.
// Depends on tll_pkg for the entry type.
module tll_fifo
  import tll_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tll_entry_t push_data,
  input  logic       pop,
  output tll_entry_t pop_data,
  output logic       full,
  output logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  tll_entry_t        mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_QW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/tll_front.sv =====
// Front part: takes requests, checks the sensor kind and the table ends,
// and queues each request with its class. Depends on tll_pkg.
module tll_front
  import tll_pkg::*;
#(
  parameter int SEGMENTS = SEGMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] in_sensor_kind,
  input  logic [CNT_W-1:0]  in_raw_count,
  output logic              push,
  output tll_entry_t        push_data,
  input  logic              q_full
);

  localparam int LAST = (SEGMENTS < TABLE_POINTS - 1) ? SEGMENTS : TABLE_POINTS - 1;

  logic              full_r, full_nxt;
  logic [KIND_W-1:0] kind_r;
  logic [CNT_W-1:0]  count_r;
  logic              accept;
  logic [KIND_W-1:0] sel;
  logic [ROW_W-1:0]  row;

  assign busy   = full_r && q_full;
  assign accept = start && !busy;
  assign push   = full_r && !q_full;
  assign sel    = kind_r - 1'b1;
  assign row    = sel[ROW_W:1];

  always_comb begin
    push_data.sel   = sel;
    push_data.count = count_r;
    if ((kind_r == '0) || (int'(kind_r) > KINDS)) begin
      push_data.cls = CLS_ZERO;
    end else if (count_r <= table_count(row, IDX_W'(LAST))) begin
      push_data.cls = CLS_HIGH;
    end else if (count_r >= table_count(row, '0)) begin
      push_data.cls = CLS_LOW;
    end else begin
      push_data.cls = CLS_INTERP;
    end
  end

  always_comb begin
    full_nxt = full_r;
    if (accept) begin
      full_nxt = 1'b1;
    end else if (push) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_sensor_kind;
      count_r <= in_raw_count;
    end
  end

endmodule

// ===== rtl/tll_back.sv =====
// Back part: halving search for the segment, serial division for the fraction,
// and scaling by a reciprocal multiply. Depends on tll_pkg.
module tll_back
  import tll_pkg::*;
#(
  parameter int SEGMENTS = SEGMENTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  tll_entry_t               q_data,
  output logic                     pop,
  output logic                     out_valid,
  output logic signed [TEMP_W-1:0] out_temperature
);

  localparam int LAST = (SEGMENTS < TABLE_POINTS - 1) ? SEGMENTS : TABLE_POINTS - 1;

  tll_bk_state_t            state_r, state_nxt;
  tll_entry_t               ent_r, ent_nxt;
  logic [IDX_W-1:0]         lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CNT_W-1:0]         delta_r, delta_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [QUO_W-1:0]         quo_r, quo_nxt;
  logic [BIT_W-1:0]         bit_r, bit_nxt;
  logic [SEGSUM_W-1:0]      segsum_r, segsum_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [SPAN_W-1:0]        frac_r, frac_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [TEMP_W-1:0] out_temp_r, out_temp_nxt;

  logic [ROW_W-1:0]         row;
  logic [IDX_W:0]           mid_sum;
  logic [IDX_W-1:0]         mid;
  logic [CNT_W-1:0]         top, bot, setup_delta;
  logic [REM_W-1:0]         shifted;
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  logic signed [TEMP_W-1:0] low_lim;
  logic signed [TEMP_W:0]   total;

  assign pop             = (state_r == BK_IDLE) && !q_empty;
  assign out_valid       = out_valid_r;
  assign out_temperature = out_temp_r;

  assign row         = ent_r.sel[ROW_W:1];
  assign mid_sum     = {1'b0, lo_r} + {1'b0, hi_r} + 1'b1;
  assign mid         = mid_sum[IDX_W:1];
  assign top         = table_count(row, lo_r);
  assign bot         = table_count(row, lo_r + 1'b1);
  assign setup_delta = top - bot;
  assign shifted     = REM_W'(delta_r) << bit_r;
  assign recip_prod  = (PROD_W + RECIP_W)'(prod_r) * (PROD_W + RECIP_W)'(RECIP_M);
  assign low_lim     = limit_low(ent_r.sel);
  assign total       = {low_lim[TEMP_W-1], low_lim}
                     + $signed({2'b00, segsum_r}) + $signed({6'b000000, frac_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty && (q_data.cls == CLS_INTERP)) begin
          state_nxt = BK_SEARCH;
        end
      end
      BK_SEARCH: begin
        if (lo_r == hi_r) begin
          state_nxt = BK_SETUP;
        end
      end
      BK_SETUP: begin
        state_nxt = (setup_delta == '0) ? BK_IDLE : BK_DIV;
      end
      BK_DIV: begin
        if (bit_r == '0) begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL:   state_nxt = BK_RECIP;
      BK_RECIP: state_nxt = BK_SUM;
      BK_SUM:   state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ent_nxt       = ent_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    delta_nxt     = delta_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    bit_nxt       = bit_r;
    segsum_nxt    = segsum_r;
    prod_nxt      = prod_r;
    frac_nxt      = frac_r;
    out_valid_nxt = 1'b0;
    out_temp_nxt  = out_temp_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          ent_nxt = q_data;
          lo_nxt  = '0;
          hi_nxt  = IDX_W'(LAST - 1);
          case (q_data.cls)
            CLS_ZERO: begin
              out_valid_nxt = 1'b1;
              out_temp_nxt  = '0;
            end
            CLS_HIGH: begin
              out_valid_nxt = 1'b1;
              out_temp_nxt  = limit_high(q_data.sel);
            end
            CLS_LOW: begin
              out_valid_nxt = 1'b1;
              out_temp_nxt  = limit_low(q_data.sel);
            end
            default: begin
            end
          endcase
        end
      end
      BK_SEARCH: begin
        if (lo_r != hi_r) begin
          if (ent_r.count < table_count(row, mid)) begin
            lo_nxt = mid;
          end else begin
            hi_nxt = mid - 1'b1;
          end
        end
      end
      BK_SETUP: begin
        delta_nxt  = setup_delta;
        rem_nxt    = REM_W'(top - ent_r.count) * REM_W'(SCALE);
        quo_nxt    = '0;
        bit_nxt    = BIT_W'(QUO_TOP);
        segsum_nxt = SEGSUM_W'(span_of(ent_r.sel)) * SEGSUM_W'(lo_r);
        if (setup_delta == '0) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = limit_low(ent_r.sel);
        end
      end
      BK_DIV: begin
        if (rem_r >= shifted) begin
          rem_nxt        = rem_r - shifted;
          quo_nxt[bit_r] = 1'b1;
        end
        bit_nxt = bit_r - 1'b1;
      end
      BK_MUL: begin
        prod_nxt = PROD_W'(span_of(ent_r.sel)) * PROD_W'(quo_r);
      end
      BK_RECIP: begin
        frac_nxt = recip_prod[RECIP_SH +: SPAN_W];
      end
      BK_SUM: begin
        out_valid_nxt = 1'b1;
        out_temp_nxt  = total[TEMP_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r      <= ent_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    delta_r    <= delta_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    bit_r      <= bit_nxt;
    segsum_r   <= segsum_nxt;
    prod_r     <= prod_nxt;
    frac_r     <= frac_nxt;
    out_temp_r <= out_temp_nxt;
  end

endmodule
